// ===== sv/hdm_pkg.sv =====
package hdm_pkg;

  // Field and register widths.
  localparam int unsigned DistW     = 32;
  localparam int unsigned RowTotalW = 17;
  localparam int unsigned ColTotalW = 11;
  localparam int unsigned CfgDataW  = 17;
  localparam int unsigned CfgIdxW   = 1;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegRowTotal    = 1'd0;
  localparam logic [CfgIdxW-1:0] RegColumnTotal = 1'd1;

  typedef logic [DistW-1:0] dist_t;

  // The two directed distances of one finished matrix.
  typedef struct packed {
    dist_t a_to_b;
    dist_t b_to_a;
  } result_t;

  function automatic dist_t min_dist(input dist_t a, input dist_t b);
    min_dist = (a < b) ? a : b;
  endfunction

  function automatic dist_t max_dist(input dist_t a, input dist_t b);
    max_dist = (a > b) ? a : b;
  endfunction

endpackage

// ===== sv/hdm_cell.sv =====
// One entry of the column minimum line. On every element transfer the line
// moves one place towards the head, and the tail cell takes the new minimum.
module hdm_cell (
  input  logic                 clk_i,
  input  logic                 advance_i,
  input  logic                 is_tail_i,
  input  hdm_pkg::dist_t       neighbour_i,
  input  hdm_pkg::dist_t       new_min_i,
  output hdm_pkg::dist_t       value_o
);

  hdm_pkg::dist_t value_q;
  hdm_pkg::dist_t value_d;

  // Take the new minimum at the tail, otherwise the value of the next cell.
  always_comb begin
    value_d = value_q;
    if (advance_i) begin
      value_d = is_tail_i ? new_min_i : neighbour_i;
    end
  end

  // The line holds no meaningful value until row zero has filled it.
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

// ===== sv/hdm_result_buf.sv =====
// Output register with one skid entry, so a result can be accepted while
// an earlier one is still waiting to be taken.
module hdm_result_buf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  hdm_pkg::result_t     push_data_i,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output logic                 full_o,
  output hdm_pkg::result_t     out_data_o,
  output hdm_pkg::dist_t       symmetric_o
);

  logic             out_valid_q, out_valid_d;
  logic             skid_valid_q, skid_valid_d;
  hdm_pkg::result_t out_data_q, out_data_d;
  hdm_pkg::result_t skid_data_q, skid_data_d;

  // Refill the output register from the skid entry first, then from a push.
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_data_d   = out_data_q;
    skid_data_d  = skid_data_q;
    if (!out_valid_q || !out_stall_i) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_data_d   = skid_data_q;
        skid_valid_d = push_i;
        skid_data_d  = push_data_i;
      end else begin
        out_valid_d  = push_i;
        out_data_d   = push_data_i;
      end
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_data_d  = push_data_i;
    end
  end

  // Valid flags are reset; the data registers need not be.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign full_o      = skid_valid_q;
  assign out_data_o  = out_data_q;
  assign symmetric_o = hdm_pkg::max_dist(out_data_q.a_to_b, out_data_q.b_to_a);

endmodule

// ===== sv/hausdorff_distance_from_matrix_top.sv =====
// A matrix's result is registered at the output, or in the skid entry while the
// output is held, when its last element is transferred. One element per cycle;
// the input stalls only while two finished results wait at the output. The line of
// column minima moves one place per element, so each reads the head cell only.
// Reset clears counters, row minimum, both maxima and sets a 1 x 1 matrix;
// the column line is not cleared, as row zero always fills it before use.
module hausdorff_distance_from_matrix_top #(
  parameter int unsigned MAX_COLUMNS = 1024,
  parameter int unsigned MAX_ROWS    = 65536
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [hdm_pkg::DistW-1:0]     distance_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [hdm_pkg::DistW-1:0]     symmetric_distance_o,
  output logic [hdm_pkg::DistW-1:0]     distance_a_to_b_o,
  output logic [hdm_pkg::DistW-1:0]     distance_b_to_a_o,
  input  logic                          cfg_we_i,
  input  logic [hdm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [hdm_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned ColIdxW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int unsigned RowIdxW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam logic [31:0] MaxColsL = 32'(MAX_COLUMNS);
  localparam logic [31:0] MaxRowsL = 32'(MAX_ROWS);

  // Clamped dimensions, held as last index.
  logic [ColIdxW-1:0] cols_m1_q, cols_m1_d;
  logic [RowIdxW-1:0] rows_m1_q, rows_m1_d;
  logic               restart;

  // Matrix position and running values.
  logic [ColIdxW-1:0] col_q, col_d;
  logic [RowIdxW-1:0] row_q, row_d;
  hdm_pkg::dist_t     row_min_q, row_min_d;
  hdm_pkg::dist_t     max_ab_q, max_ab_d;
  hdm_pkg::dist_t     max_ba_q, max_ba_d;

  logic               accept;
  logic               last_col;
  logic               last_row;
  logic               produce;
  logic               buf_full;
  hdm_pkg::dist_t     head;
  hdm_pkg::dist_t     rmin;
  hdm_pkg::dist_t     cmin;
  hdm_pkg::result_t   result;
  hdm_pkg::result_t   out_data;
  hdm_pkg::dist_t     line [MAX_COLUMNS];

  // Configuration decode with clamping of both dimensions.
  always_comb begin
    logic [31:0] rt;
    logic [31:0] ct;
    rt        = 32'(cfg_data_i[hdm_pkg::RowTotalW-1:0]);
    ct        = 32'(cfg_data_i[hdm_pkg::ColTotalW-1:0]);
    rows_m1_d = rows_m1_q;
    cols_m1_d = cols_m1_q;
    restart   = 1'b0;
    if (cfg_we_i) begin
      restart = 1'b1;
      unique case (cfg_index_i)
        hdm_pkg::RegRowTotal: begin
          if (rt == 32'd0)         rows_m1_d = '0;
          else if (rt > MaxRowsL)  rows_m1_d = RowIdxW'(MaxRowsL - 32'd1);
          else                     rows_m1_d = RowIdxW'(rt - 32'd1);
        end
        hdm_pkg::RegColumnTotal: begin
          if (ct == 32'd0)         cols_m1_d = '0;
          else if (ct > MaxColsL)  cols_m1_d = ColIdxW'(MaxColsL - 32'd1);
          else                     cols_m1_d = ColIdxW'(ct - 32'd1);
        end
        default: restart = 1'b1;
      endcase
    end
  end

  assign accept   = in_valid_i && !buf_full;
  assign last_col = (col_q == cols_m1_q);
  assign last_row = (row_q == rows_m1_q);
  assign produce  = accept && !cfg_we_i && last_col && last_row;
  assign head     = line[0];

  // Row and column minima for the element at hand.
  assign rmin = (col_q == '0) ? distance_i : hdm_pkg::min_dist(row_min_q, distance_i);
  assign cmin = (row_q == '0) ? distance_i : hdm_pkg::min_dist(head, distance_i);

  assign result.a_to_b = hdm_pkg::max_dist(max_ab_q, rmin);
  assign result.b_to_a = hdm_pkg::max_dist(max_ba_q, cmin);

  // Position, running minimum and maxima.
  always_comb begin
    col_d     = col_q;
    row_d     = row_q;
    row_min_d = row_min_q;
    max_ab_d  = max_ab_q;
    max_ba_d  = max_ba_q;
    if (restart) begin
      col_d     = '0;
      row_d     = '0;
      row_min_d = '0;
      max_ab_d  = '0;
      max_ba_d  = '0;
    end else if (accept) begin
      row_min_d = rmin;
      if (last_col) max_ab_d = result.a_to_b;
      if (last_row) max_ba_d = result.b_to_a;
      if (last_col) begin
        col_d = '0;
        if (last_row) begin
          row_d     = '0;
          row_min_d = '0;
          max_ab_d  = '0;
          max_ba_d  = '0;
        end else begin
          row_d = row_q + RowIdxW'(1);
        end
      end else begin
        col_d = col_q + ColIdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_m1_q <= '0;
      rows_m1_q <= '0;
      col_q     <= '0;
      row_q     <= '0;
      row_min_q <= '0;
      max_ab_q  <= '0;
      max_ba_q  <= '0;
    end else begin
      cols_m1_q <= cols_m1_d;
      rows_m1_q <= rows_m1_d;
      col_q     <= col_d;
      row_q     <= row_d;
      row_min_q <= row_min_d;
      max_ab_q  <= max_ab_d;
      max_ba_q  <= max_ba_d;
    end
  end

  // Line of column minima; the cell at the configured last column index is the tail.
  for (genvar i = 0; i < MAX_COLUMNS; i++) begin : g_cell
    hdm_pkg::dist_t neighbour;
    if (i == MAX_COLUMNS - 1) begin : g_end
      assign neighbour = cmin;
    end else begin : g_mid
      assign neighbour = line[i+1];
    end
    hdm_cell u_cell (
      .clk_i       (clk_i),
      .advance_i   (accept && !cfg_we_i),
      .is_tail_i   (cols_m1_q == ColIdxW'(i)),
      .neighbour_i (neighbour),
      .new_min_i   (cmin),
      .value_o     (line[i])
    );
  end

  // Result buffer towards the output channel.
  hdm_result_buf u_result_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (produce),
    .push_data_i (result),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .full_o      (buf_full),
    .out_data_o  (out_data),
    .symmetric_o (symmetric_distance_o)
  );

  assign in_stall_o        = buf_full;
  assign distance_a_to_b_o = out_data.a_to_b;
  assign distance_b_to_a_o = out_data.b_to_a;

endmodule

// ===== sv/hdm_checker.sv =====
// Port-level checks for the Hausdorff distance block.
module hdm_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_stall_o,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic [hdm_pkg::DistW-1:0] symmetric_distance_o,
  input logic [hdm_pkg::DistW-1:0] distance_a_to_b_o,
  input logic [hdm_pkg::DistW-1:0] distance_b_to_a_o
);

  // The symmetric distance is the larger of the two directed distances.
  a_sym_is_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((symmetric_distance_o == distance_a_to_b_o ||
                      symmetric_distance_o == distance_b_to_a_o) &&
                     symmetric_distance_o >= distance_a_to_b_o &&
                     symmetric_distance_o >= distance_b_to_a_o))
    else $error("symmetric distance is not the maximum of both directions");

  // The input stalls only while a result is waiting at the output.
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled without a pending result");

  // The input starts to stall only after the output was held back.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stall rose without output back-pressure");

  // A held result stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(symmetric_distance_o) &&
      $stable(distance_a_to_b_o) && $stable(distance_b_to_a_o))
    else $error("stalled result changed");

endmodule

bind hausdorff_distance_from_matrix_top hdm_checker u_hdm_checker (.*);
